>>> design/clb_pkg.sv
// Shared types and constants for the 3D table color lookup block.
// No dependencies; the front, back and top files refer to this package by scoped names.
package clb_pkg;

  // address field wide enough for the largest supported grid (63 points per axis)
  localparam int LUT_ADDR_W = 19;

  // queue depths (powers of two) and their fill count widths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 16;
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] REG_LUT_DIM         = 2'd0;
  localparam logic [1:0] REG_SAMPLE_DEPTH    = 2'd1;
  localparam logic [1:0] REG_BLEND_INTENSITY = 2'd2;

  // arithmetic constants
  localparam logic [5:0]  DIM_MIN       = 6'd2;
  localparam logic [6:0]  INTEN_MAX     = 7'd100;
  localparam logic [15:0] RESCALE_MUL   = 16'hFF01;   // floor(n/257) = (n*0xFF01) >> 24
  localparam int          RESCALE_SHIFT = 24;
  localparam logic [23:0] RECIP_100     = 24'd10737419; // ceil(2^30/100)
  localparam int          RECIP_SHIFT   = 30;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } item_kind_t;

  // input word
  typedef struct packed {
    logic        req_type;
    logic [15:0] entry_index;
    logic [15:0] entry_red;
    logic [15:0] entry_green;
    logic [15:0] entry_blue;
    logic [15:0] pixel_red;
    logic [15:0] pixel_green;
    logic [15:0] pixel_blue;
    logic [15:0] pixel_alpha;
  } req_t;

  // result word
  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } res_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [5:0]  dim;
    logic [11:0] dim_sq;
    logic        depth16;
    logic [6:0]  inten;
  } cfg_t;

  // per pixel data that rides along the datapath; channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [2:0][15:0] frac;
    logic [2:0][15:0] val;
    logic [15:0]      alpha;
  } side_t;

  // classified word between front and back
  typedef struct packed {
    item_kind_t              kind;
    logic [LUT_ADDR_W-1:0]   addr;   // entry index for loads, cell base for pixels
    logic [47:0]             ent;    // red, green, blue of a load
    side_t                   side;
  } work_t;

endpackage

>>> design/clb_fifo.sv
// Small register queue with fill count, used between front and back and at the output.
// Depends on nothing; DEPTH must be a power of two.
module clb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) store[wptr] <= wr_data;
  end

  assign rd_data = store[rptr];
  assign empty   = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CW'(DEPTH)))
    else $error("word pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("word popped from an empty queue");

endmodule

>>> design/clb_front.sv
// Front end: accepts words, scales pixel samples into cell index and fraction, forms the
// cell base address and hands classified words to the middle queue. Uses clb_pkg.
module clb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  clb_pkg::req_t                  req,
  output logic                           full,
  input  clb_pkg::cfg_t                  cfg,
  input  logic [clb_pkg::MID_CNT_W-1:0]  mid_count,
  output logic                           mid_push,
  output clb_pkg::work_t                 mid_word
);

  localparam int SW = clb_pkg::MID_CNT_W + 1;

  logic           accept;
  logic           f1_v;
  clb_pkg::req_t  f1_req;
  logic           f2_v;
  clb_pkg::work_t f2_word;
  logic [5:0]     f2_cell [3];

  logic [15:0]    pix      [3];
  logic [15:0]    samp     [3];
  logic [21:0]    scaled   [3];
  logic [5:0]     cell_idx [3];
  logic [5:0]     dim_m1;
  clb_pkg::work_t f1_word;
  logic [11:0]    prod_b;
  logic [17:0]    prod_g;
  logic [clb_pkg::LUT_ADDR_W-1:0] base;

  // credit: queue fill plus words still in the front must leave a free slot
  assign full   = (SW'(mid_count) + SW'(f1_v) + SW'(f2_v)) >= SW'(clb_pkg::MID_DEPTH);
  assign accept = push & ~full;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      f1_v <= accept;
      f2_v <= f1_v;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) f1_req <= req;
    f2_word <= f1_word;
    for (int k = 0; k < 3; k++) f2_cell[k] <= cell_idx[k];
  end

  // sample scaling: t = v*(dim-1), cell = t >> depth, fraction made 0.16
  assign pix[0] = f1_req.pixel_red;
  assign pix[1] = f1_req.pixel_green;
  assign pix[2] = f1_req.pixel_blue;
  assign dim_m1 = cfg.dim - 6'd1;

  always_comb begin
    f1_word            = '0;
    f1_word.kind       = clb_pkg::item_kind_t'(f1_req.req_type);
    f1_word.addr       = clb_pkg::LUT_ADDR_W'(f1_req.entry_index);
    f1_word.ent        = {f1_req.entry_red, f1_req.entry_green, f1_req.entry_blue};
    f1_word.side.alpha = f1_req.pixel_alpha;
    for (int k = 0; k < 3; k++) begin
      samp[k]     = cfg.depth16 ? pix[k] : {8'h00, pix[k][7:0]};
      scaled[k]   = 22'(samp[k]) * 22'(dim_m1);
      cell_idx[k] = cfg.depth16 ? scaled[k][21:16] : scaled[k][13:8];
      f1_word.side.val[k]  = samp[k];
      f1_word.side.frac[k] = cfg.depth16 ? scaled[k][15:0] : {scaled[k][7:0], 8'h00};
    end
  end

  // cell base: red + blue*dim + green*dim^2
  assign prod_b = 12'(f2_cell[2]) * 12'(cfg.dim);
  assign prod_g = 18'(f2_cell[1]) * 18'(cfg.dim_sq);
  assign base   = clb_pkg::LUT_ADDR_W'(f2_cell[0]) + clb_pkg::LUT_ADDR_W'(prod_b)
                + clb_pkg::LUT_ADDR_W'(prod_g);

  always_comb begin
    mid_word = f2_word;
    if (f2_word.kind == clb_pkg::KIND_PIXEL) mid_word.addr = base;
  end

  assign mid_push = f2_v;

  a_mid_room: assert property (@(posedge clk) disable iff (rst)
    f2_v |-> (mid_count < clb_pkg::MID_CNT_W'(clb_pkg::MID_DEPTH)))
    else $error("front credit let a word reach a full middle queue");

endmodule

>>> design/clb_back.sv
// Back end: table memories (eight copies, one per cell corner), trilinear datapath,
// 8-bit rescale and blend. Uses clb_pkg; feeds the output queue.
module clb_back #(
  parameter int MAX_DIM = 33
) (
  input  logic                           clk,
  input  logic                           rst,
  input  clb_pkg::cfg_t                  cfg,
  input  clb_pkg::work_t                 mid_word,
  input  logic                           mid_empty,
  output logic                           mid_pop,
  input  logic [clb_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                           out_push,
  output clb_pkg::res_t                  out_word
);

  localparam int LUT_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(LUT_DEPTH);
  localparam int SW        = clb_pkg::OUT_CNT_W + 1;
  localparam int NST       = 7;

  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] f);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [33:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    s = $signed({2'b00, a, 16'h0000}) + p;
    return s[31:16];
  endfunction

  logic [NST:1]                   pv;
  clb_pkg::side_t                 side [1:NST];
  logic [3:0]                     inflight;
  logic                           we;
  logic [clb_pkg::LUT_ADDR_W-1:0] raddr [8];
  logic [47:0]                    rd    [8];
  logic [15:0]                    lr    [3][4];
  logic [15:0]                    lb    [3][2];
  logic [15:0]                    n4    [3];
  logic [15:0]                    n5    [3];
  logic [31:0]                    prod5 [3];
  logic [22:0]                    x6    [3];
  logic [46:0]                    y7    [3];
  logic [15:0]                    nn    [3];
  logic [6:0]                     inten_c;

  // pop only when the output queue has room for everything in flight
  assign inflight = 4'($countones(pv));
  assign mid_pop  = ~mid_empty &
                    ((SW'(out_count) + SW'(inflight)) < SW'(clb_pkg::OUT_DEPTH));
  assign we       = mid_pop & (mid_word.kind == clb_pkg::KIND_LOAD) &
                    (mid_word.addr < clb_pkg::LUT_ADDR_W'(LUT_DEPTH));

  // corner addresses: bit 0 steps red, bit 1 steps blue, bit 2 steps green
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      raddr[k] = mid_word.addr
               + ((k % 2) != 0 ? clb_pkg::LUT_ADDR_W'(1) : '0)
               + (((k / 2) % 2) != 0 ? clb_pkg::LUT_ADDR_W'(cfg.dim) : '0)
               + ((k / 4) != 0 ? clb_pkg::LUT_ADDR_W'(cfg.dim_sq) : '0);
    end
  end

  // table copies, each written with every load and read at one corner
  for (genvar k = 0; k < 8; k++) begin : g_copy
    logic [47:0] mem [LUT_DEPTH];
    always_ff @(posedge clk) begin
      if (we) begin
        mem[mid_word.addr[AW-1:0]] <= mid_word.ent;
      end else if (mid_pop) begin
        rd[k] <= mem[raddr[k][AW-1:0]];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[NST-1:1], mid_pop & (mid_word.kind == clb_pkg::KIND_PIXEL)};
    end
  end

  // side data shift line
  always_ff @(posedge clk) begin
    side[1] <= mid_word.side;
    for (int s = 2; s <= NST; s++) side[s] <= side[s-1];
  end

  assign inten_c = clb_pkg::INTEN_MAX - cfg.inten;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nn[c] = cfg.depth16 ? n5[c]
                          : {8'h00, prod5[c][clb_pkg::RESCALE_SHIFT +: 8]};
    end
  end

  // datapath: red, blue, green interpolation, rescale, blend, divide by hundred
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 4; j++) begin
        lr[c][j] <= lerp16(rd[2*j][47-16*c -: 16], rd[2*j+1][47-16*c -: 16],
                           side[1].frac[0]);
      end
      lb[c][0] <= lerp16(lr[c][0], lr[c][1], side[2].frac[2]);
      lb[c][1] <= lerp16(lr[c][2], lr[c][3], side[2].frac[2]);
      n4[c]    <= lerp16(lb[c][0], lb[c][1], side[3].frac[1]);
      n5[c]    <= n4[c];
      prod5[c] <= 32'(n4[c]) * 32'(clb_pkg::RESCALE_MUL);
      x6[c]    <= 23'(inten_c) * 23'(side[5].val[c]) + 23'(cfg.inten) * 23'(nn[c]);
      y7[c]    <= 47'(x6[c]) * 47'(clb_pkg::RECIP_100);
    end
  end

  assign out_push           = pv[NST];
  assign out_word.out_red   = y7[0][clb_pkg::RECIP_SHIFT +: 16];
  assign out_word.out_green = y7[1][clb_pkg::RECIP_SHIFT +: 16];
  assign out_word.out_blue  = y7[2][clb_pkg::RECIP_SHIFT +: 16];
  assign out_word.out_alpha = side[NST].alpha;

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_count < clb_pkg::OUT_CNT_W'(clb_pkg::OUT_DEPTH)))
    else $error("result reached a full output queue");

endmodule

>>> design/color_lut3d_trilinear_blend.sv
// 3D table color lookup with trilinear interpolation and intensity blend.
// A pixel word passes the front stages, middle queue and back pipeline before empty goes low.
// Throughput: one word per clock; stalls come only from the output queue filling.
// Table entries are read through eight single-port copies, one per cell corner.
// Reset clears control and loads register defaults; no table clearing pass,
// entries are undefined until loaded. Uses clb_pkg, clb_front, clb_fifo, clb_back.
module color_lut3d_trilinear_blend #(
  parameter int MAX_DIM = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  clb_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output clb_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data
);

  localparam int DIM_CAP = (MAX_DIM > 63) ? 63 : MAX_DIM;
  localparam int DIM_RST = (MAX_DIM < 33) ? MAX_DIM : 33;

  clb_pkg::cfg_t                  cfg;
  clb_pkg::cfg_t                  cfg_next;
  logic [5:0]                     dim_new;
  logic                           mid_push;
  clb_pkg::work_t                 mid_in;
  logic [$bits(clb_pkg::work_t)-1:0] mid_out;
  logic                           mid_pop;
  logic                           mid_empty;
  logic [clb_pkg::MID_CNT_W-1:0]  mid_count;
  logic                           out_push;
  clb_pkg::res_t                  out_in;
  logic [$bits(clb_pkg::res_t)-1:0] out_rd;
  logic [clb_pkg::OUT_CNT_W-1:0]  out_count;

  assign cfg_ready = 1'b1;

  // register writes, clamped on the way in
  always_comb begin
    cfg_next = cfg;
    if (cfg_data[5:0] < clb_pkg::DIM_MIN) begin
      dim_new = clb_pkg::DIM_MIN;
    end else if (7'(cfg_data[5:0]) > 7'(DIM_CAP)) begin
      dim_new = 6'(DIM_CAP);
    end else begin
      dim_new = cfg_data[5:0];
    end
    if (cfg_valid) begin
      case (cfg_index)
        clb_pkg::REG_LUT_DIM: begin
          cfg_next.dim    = dim_new;
          cfg_next.dim_sq = 12'(dim_new) * 12'(dim_new);
        end
        clb_pkg::REG_SAMPLE_DEPTH: begin
          cfg_next.depth16 = cfg_data[0];
        end
        clb_pkg::REG_BLEND_INTENSITY: begin
          cfg_next.inten = (cfg_data > clb_pkg::INTEN_MAX) ? clb_pkg::INTEN_MAX : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim     <= 6'(DIM_RST);
      cfg.dim_sq  <= 12'(DIM_RST * DIM_RST);
      cfg.depth16 <= 1'b0;
      cfg.inten   <= clb_pkg::INTEN_MAX;
    end else begin
      cfg <= cfg_next;
    end
  end

  clb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req       (req),
    .full      (full),
    .cfg       (cfg),
    .mid_count (mid_count),
    .mid_push  (mid_push),
    .mid_word  (mid_in)
  );

  clb_fifo #(
    .WIDTH ($bits(clb_pkg::work_t)),
    .DEPTH (clb_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_in),
    .pop     (mid_pop),
    .rd_data (mid_out),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  clb_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_word  (clb_pkg::work_t'(mid_out)),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_word  (out_in)
  );

  clb_fifo #(
    .WIDTH ($bits(clb_pkg::res_t)),
    .DEPTH (clb_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_in),
    .pop     (pop & ~empty),
    .rd_data (out_rd),
    .empty   (empty),
    .count   (out_count)
  );

  assign res = clb_pkg::res_t'(out_rd);

endmodule
